@@ rtl/pcwr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcwr_pkg
// shared types, codes and defaults of the priority column width resizer
// ----------------------------------------------------------------------------
package pcwr_pkg;

    localparam int unsigned MAX_COLUMNS_DEF = 16;
    localparam int unsigned WIDTH_BITS_DEF  = 16;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned COL_W   = 6;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned PADDR_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_SPEC  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_WIDTH = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESIZE_ALL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESIZE_ONE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_WIDTH  = 3'd4;

    // register word index (paddr bit 2)
    localparam logic REG_NUM_COLUMNS = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COL_W-1:0]   column;
        logic [FIELD_W-1:0] min_width;
        logic [FIELD_W-1:0] max_width;
        logic               has_max;
        logic [PRIO_W-1:0]  priority_req;
        logic [FIELD_W-1:0] width_value;
        logic [FIELD_W-1:0] total_width;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]   out_column;
        logic [FIELD_W-1:0] out_width;
        logic               changed;
        logic               last;
    } t_out_item;

    typedef enum logic [1:0] {
        SCOPE_RIGHT,
        SCOPE_FOCUS,
        SCOPE_ALL
    } t_scope;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_WSPEC,
        OP_WWIDTH,
        OP_FOCUS,
        OP_READ,
        OP_CLAMP,
        OP_SET_START,
        OP_SUM_ACC,
        OP_DELTA,
        OP_FLEX,
        OP_FIND_INIT,
        OP_FIND,
        OP_LVL_SET,
        OP_ROOM_INIT,
        OP_DIV_START,
        OP_DIV_TAKE,
        OP_SHARE,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_RR_ADDR,
        OP_RR,
        OP_PASS_INC,
        OP_EMIT_INIT,
        OP_EMIT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_READ_RD,
        S_READ_OP,
        S_CLAMP_RD,
        S_CLAMP_OP,
        S_START,
        S_SUM_RD,
        S_SUM_OP,
        S_DELTA,
        S_FLEX_RD,
        S_FLEX_OP,
        S_LVL_INIT,
        S_FIND_RD,
        S_FIND_OP,
        S_LVL_SET,
        S_ROOM_RD,
        S_ROOM_OP,
        S_PASS_CHK,
        S_DIV_WAIT,
        S_SHARE_RD,
        S_SHARE_OP,
        S_RR_CHK,
        S_MOD,
        S_RR_RD,
        S_RR_OP,
        S_FIT_END,
        S_EMIT_RD,
        S_EMIT_OP
    } t_state;

    typedef struct packed {
        t_op    op;
        t_scope scope;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             col_in_use;
        logic             at_end;
        logic             scope_empty;
        logic             delta_zero;
        logic             rem_zero;
        logic             found;
        logic             share_cont;
        logic             rr_needed;
        logic             mod_done;
        logic             rr_cont;
        logic             div_done;
        logic             out_free;
    } t_dp_status;

endpackage
`default_nettype wire

@@ rtl/pcwr_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcwr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pcwr_div #(
    parameter int unsigned DW = 23,
    parameter int unsigned VW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_busy,
    output logic [DW-1:0]      o_quotient
);
    localparam int unsigned CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [DW-1:0] r_quo;
    logic [VW:0]   w_shift;
    logic [VW:0]   w_diff;
    logic          w_ge;

    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(DW);
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            r_rem <= w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

@@ rtl/pcwr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcwr_ctrl
// command sequencer of the resizer
// ----------------------------------------------------------------------------
module pcwr_ctrl
    import pcwr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_idle
);
    t_state r_state, n_state;
    t_scope r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= SCOPE_ALL;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_accept) n_state = S_EXEC;
            S_EXEC: begin
                priority if (i_status.cmd == CMD_READ_WIDTH) n_state = S_READ_RD;
                else if (i_status.cmd == CMD_RESIZE_ALL) n_state = S_START;
                else if (i_status.cmd == CMD_RESIZE_ONE)
                    n_state = i_status.col_in_use ? S_CLAMP_RD : S_EMIT_RD;
                else n_state = S_IDLE;
            end
            S_READ_RD:  n_state = S_READ_OP;
            S_READ_OP:  if (i_status.out_free) n_state = S_IDLE;
            S_CLAMP_RD: n_state = S_CLAMP_OP;
            S_CLAMP_OP: n_state = S_START;
            S_START:    n_state = S_SUM_RD;
            S_SUM_RD:   n_state = i_status.at_end ? S_DELTA : S_SUM_OP;
            S_SUM_OP:   n_state = S_SUM_RD;
            S_DELTA:    n_state = (i_status.scope_empty || i_status.delta_zero) ?
                                  S_FIT_END : S_FLEX_RD;
            S_FLEX_RD:  n_state = i_status.at_end ? S_LVL_INIT : S_FLEX_OP;
            S_FLEX_OP:  n_state = S_FLEX_RD;
            S_LVL_INIT: n_state = i_status.rem_zero ? S_FIT_END : S_FIND_RD;
            S_FIND_RD:  n_state = i_status.at_end ? S_LVL_SET : S_FIND_OP;
            S_FIND_OP:  n_state = S_FIND_RD;
            S_LVL_SET:  n_state = i_status.found ? S_ROOM_RD : S_FIT_END;
            S_ROOM_RD:  n_state = i_status.at_end ? S_PASS_CHK : S_ROOM_OP;
            S_ROOM_OP:  n_state = S_ROOM_RD;
            S_PASS_CHK: n_state = i_status.share_cont ? S_DIV_WAIT : S_LVL_INIT;
            S_DIV_WAIT: if (i_status.div_done) n_state = S_SHARE_RD;
            S_SHARE_RD: n_state = (i_status.at_end || i_status.rem_zero) ?
                                  S_RR_CHK : S_SHARE_OP;
            S_SHARE_OP: n_state = S_SHARE_RD;
            S_RR_CHK:   n_state = i_status.rr_needed ? S_MOD : S_PASS_CHK;
            S_MOD:      if (i_status.mod_done) n_state = S_RR_RD;
            S_RR_RD:    n_state = i_status.rr_cont ? S_RR_OP : S_PASS_CHK;
            S_RR_OP:    n_state = S_RR_RD;
            S_FIT_END:  n_state = (r_phase == SCOPE_ALL) ? S_EMIT_RD : S_START;
            S_EMIT_RD:  n_state = i_status.at_end ? S_IDLE : S_EMIT_OP;
            S_EMIT_OP:  if (i_status.out_free) n_state = S_EMIT_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.scope = r_phase;
        n_phase     = r_phase;
        unique case (r_state)
            S_IDLE:     if (i_accept) o_cmd.op = OP_LOAD;
            S_EXEC: begin
                priority if (i_status.cmd == CMD_WRITE_SPEC) o_cmd.op = OP_WSPEC;
                else if (i_status.cmd == CMD_WRITE_WIDTH) o_cmd.op = OP_WWIDTH;
                else if (i_status.cmd == CMD_READ_WIDTH) o_cmd.op = OP_FOCUS;
                else if (i_status.cmd == CMD_RESIZE_ALL) n_phase = SCOPE_ALL;
                else if (i_status.cmd == CMD_RESIZE_ONE) begin
                    n_phase  = SCOPE_RIGHT;
                    o_cmd.op = i_status.col_in_use ? OP_FOCUS : OP_EMIT_INIT;
                end
            end
            S_READ_OP:  if (i_status.out_free) o_cmd.op = OP_READ;
            S_CLAMP_OP: o_cmd.op = OP_CLAMP;
            S_START:    o_cmd.op = OP_SET_START;
            S_SUM_OP:   o_cmd.op = OP_SUM_ACC;
            S_DELTA:    o_cmd.op = OP_DELTA;
            S_FLEX_OP:  o_cmd.op = OP_FLEX;
            S_LVL_INIT: if (!i_status.rem_zero) o_cmd.op = OP_FIND_INIT;
            S_FIND_OP:  o_cmd.op = OP_FIND;
            S_LVL_SET:  if (i_status.found) o_cmd.op = OP_LVL_SET;
            S_ROOM_OP:  o_cmd.op = OP_ROOM_INIT;
            S_PASS_CHK: if (i_status.share_cont) o_cmd.op = OP_DIV_START;
            S_DIV_WAIT: if (i_status.div_done) o_cmd.op = OP_DIV_TAKE;
            S_SHARE_OP: o_cmd.op = OP_SHARE;
            S_RR_CHK:   o_cmd.op = i_status.rr_needed ? OP_MOD_INIT : OP_PASS_INC;
            S_MOD:      o_cmd.op = i_status.mod_done ? OP_RR_ADDR : OP_MOD_STEP;
            S_RR_RD:    if (!i_status.rr_cont) o_cmd.op = OP_PASS_INC;
            S_RR_OP:    o_cmd.op = OP_RR;
            S_FIT_END: begin
                priority if (r_phase == SCOPE_ALL) o_cmd.op = OP_EMIT_INIT;
                else if (r_phase == SCOPE_RIGHT) n_phase = SCOPE_FOCUS;
                else n_phase = SCOPE_ALL;
            end
            S_EMIT_OP:  if (i_status.out_free) o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);
endmodule
`default_nettype wire

@@ rtl/pcwr_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcwr_dp
// column tables, scope arithmetic and result register
// ----------------------------------------------------------------------------
module pcwr_dp
    import pcwr_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int unsigned WIDTH_BITS  = WIDTH_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire t_in_item         i_item,
    input  wire logic [CFG_W-1:0] i_num_columns,
    input  wire logic             i_out_stall,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);
    localparam int unsigned IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int unsigned SW = (WIDTH_BITS + 7 > 17) ? WIDTH_BITS + 7 : 17;
    localparam logic [WIDTH_BITS-1:0] WMAX = '1;
    localparam logic [CFG_W-1:0]      MAXC = CFG_W'(MAX_COLUMNS);

    // column tables
    logic [WIDTH_BITS-1:0] min_mem   [MAX_COLUMNS];
    logic [WIDTH_BITS-1:0] max_mem   [MAX_COLUMNS];
    logic                  bnd_mem   [MAX_COLUMNS];
    logic [PRIO_W-1:0]     prio_mem  [MAX_COLUMNS];
    logic [WIDTH_BITS-1:0] width_mem [MAX_COLUMNS];
    logic [WIDTH_BITS-1:0] flex_mem  [MAX_COLUMNS];
    logic [WIDTH_BITS-1:0] room_mem  [MAX_COLUMNS];

    logic [WIDTH_BITS-1:0] r_min_q, r_max_q, r_width_q, r_flex_q, r_room_q;
    logic                  r_bnd_q;
    logic [PRIO_W-1:0]     r_prio_q;

    t_in_item          r_item;
    logic [CFG_W-1:0]  r_n, r_start, r_col, r_active, r_pass, r_k, r_j;
    logic [SW-1:0]     r_sum, r_rem, r_each;
    logic              r_expand, r_found, r_changed, r_ov;
    logic [8:0]        r_curp;
    logic [PRIO_W-1:0] r_best;
    logic [COL_W-1:0]  r_rot;
    t_out_item         r_od;

    logic [CFG_W-1:0]      w_cnt, w_knext, w_focus;
    logic [CFG_W:0]        w_cnt1;
    logic [SW-1:0]         w_target, w_quo;
    logic [WIDTH_BITS-1:0] w_flex, w_lim, w_room_init, w_add, w_share_w, w_rr_w;
    logic [WIDTH_BITS-1:0] w_clamp, w_mn, w_mx, w_wr_width;
    logic [IW-1:0]         w_waddr, w_raddr;
    logic                  w_width_we, w_col_ok, w_div_busy, w_out_free;

    assign w_cnt    = r_n - r_start;
    assign w_cnt1   = {1'b0, w_cnt} + (CFG_W+1)'(1);
    assign w_target = SW'(r_item.total_width);
    assign w_focus  = {1'b0, r_item.column};
    assign w_col_ok = w_focus < MAXC;
    assign w_knext  = (r_k + CFG_W'(1) == w_cnt) ? '0 : r_k + CFG_W'(1);
    assign w_out_free = !r_ov || !i_out_stall;

    always_comb begin
        w_lim = WMAX - r_width_q;
        if (r_expand) begin
            if (r_bnd_q) w_flex = (r_width_q > r_max_q) ? '0 : r_max_q - r_width_q;
            else w_flex = (r_rem < SW'(w_lim)) ? WIDTH_BITS'(r_rem) : w_lim;
        end else begin
            w_flex = (r_width_q < r_min_q) ? '0 : r_width_q - r_min_q;
        end
        w_room_init = ({1'b0, r_prio_q} == r_curp) ? r_flex_q : '0;
        w_add       = (SW'(r_room_q) < r_each) ? r_room_q : WIDTH_BITS'(r_each);
        w_share_w   = r_expand ? r_width_q + w_add : r_width_q - w_add;
        w_rr_w      = r_expand ? r_width_q + WIDTH_BITS'(1) : r_width_q - WIDTH_BITS'(1);
        w_clamp     = (r_width_q < r_min_q) ? r_min_q : r_width_q;
        if (r_bnd_q && w_clamp > r_max_q) w_clamp = r_max_q;
        w_mn = WIDTH_BITS'(r_item.min_width);
        w_mx = WIDTH_BITS'(r_item.max_width);
        if (w_mx < w_mn) w_mx = w_mn;
    end

    // width table write port
    always_comb begin
        w_width_we = 1'b0;
        w_wr_width = w_share_w;
        unique case (i_cmd.op)
            OP_WWIDTH: begin
                w_width_we = w_col_ok;
                w_wr_width = WIDTH_BITS'(r_item.width_value);
            end
            OP_CLAMP: begin
                w_width_we = 1'b1;
                w_wr_width = w_clamp;
            end
            OP_SHARE: w_width_we = (r_room_q != '0);
            OP_RR: begin
                w_width_we = (r_room_q != '0);
                w_wr_width = w_rr_w;
            end
            default: w_width_we = 1'b0;
        endcase
    end

    assign w_raddr = r_col[IW-1:0];
    assign w_waddr = (i_cmd.op == OP_WSPEC || i_cmd.op == OP_WWIDTH) ?
                     r_item.column[IW-1:0] : r_col[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WSPEC && w_col_ok) begin
            min_mem[w_waddr]  <= w_mn;
            max_mem[w_waddr]  <= w_mx;
            bnd_mem[w_waddr]  <= r_item.has_max;
            prio_mem[w_waddr] <= r_item.priority_req;
        end
        if (w_width_we) width_mem[w_waddr] <= w_wr_width;
        if (i_cmd.op == OP_FLEX) flex_mem[w_waddr] <= w_flex;
        if (i_cmd.op == OP_ROOM_INIT) room_mem[w_waddr] <= w_room_init;
        else if (i_cmd.op == OP_SHARE && r_room_q != '0)
            room_mem[w_waddr] <= r_room_q - w_add;
        else if (i_cmd.op == OP_RR && r_room_q != '0)
            room_mem[w_waddr] <= r_room_q - WIDTH_BITS'(1);
        r_min_q   <= min_mem[w_raddr];
        r_max_q   <= max_mem[w_raddr];
        r_bnd_q   <= bnd_mem[w_raddr];
        r_prio_q  <= prio_mem[w_raddr];
        r_width_q <= width_mem[w_raddr];
        r_flex_q  <= flex_mem[w_raddr];
        r_room_q  <= room_mem[w_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_rot <= '0;
        end else begin
            if (i_cmd.op == OP_EMIT || i_cmd.op == OP_READ) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
            if (i_cmd.op == OP_RR) r_rot <= w_knext[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_item    <= i_item;
                r_n       <= (i_num_columns > MAXC) ? MAXC : i_num_columns;
                r_changed <= 1'b0;
            end
            OP_FOCUS: r_col <= w_focus;
            OP_READ: begin
                r_od.out_column <= r_item.column;
                r_od.out_width  <= w_col_ok ? FIELD_W'(r_width_q) : '0;
                r_od.changed    <= 1'b0;
                r_od.last       <= 1'b1;
            end
            OP_CLAMP: if (w_clamp != r_width_q) r_changed <= 1'b1;
            OP_SET_START: begin
                unique case (i_cmd.scope)
                    SCOPE_RIGHT: r_start <= w_focus + CFG_W'(1);
                    SCOPE_FOCUS: r_start <= w_focus;
                    default:     r_start <= '0;
                endcase
                r_col <= '0;
                r_sum <= '0;
            end
            OP_SUM_ACC: begin
                r_sum <= r_sum + SW'(r_width_q);
                r_col <= r_col + CFG_W'(1);
            end
            OP_DELTA: begin
                r_expand <= w_target > r_sum;
                r_rem    <= (w_target > r_sum) ? w_target - r_sum : r_sum - w_target;
                r_col    <= r_start;
                r_curp   <= 9'd256;
            end
            OP_FLEX: r_col <= r_col + CFG_W'(1);
            OP_FIND_INIT: begin
                r_found <= 1'b0;
                r_best  <= '0;
                r_col   <= r_start;
            end
            OP_FIND: begin
                if ({1'b0, r_prio_q} < r_curp && (!r_found || r_prio_q > r_best)) begin
                    r_best  <= r_prio_q;
                    r_found <= 1'b1;
                end
                r_col <= r_col + CFG_W'(1);
            end
            OP_LVL_SET: begin
                r_curp   <= {1'b0, r_best};
                r_col    <= r_start;
                r_active <= '0;
                r_pass   <= '0;
            end
            OP_ROOM_INIT: begin
                if (w_room_init != '0) r_active <= r_active + CFG_W'(1);
                r_col <= r_col + CFG_W'(1);
            end
            OP_DIV_START: r_col <= r_start;
            OP_DIV_TAKE: begin
                r_each <= w_quo;
                r_col  <= r_start;
            end
            OP_SHARE: begin
                if (r_room_q != '0) begin
                    r_rem <= r_rem - SW'(w_add);
                    if (w_add != '0) r_changed <= 1'b1;
                    if (r_room_q == w_add) r_active <= r_active - CFG_W'(1);
                end
                r_col <= r_col + CFG_W'(1);
            end
            OP_MOD_INIT: begin
                r_k <= {1'b0, r_rot};
                r_j <= '0;
            end
            OP_MOD_STEP: r_k <= r_k - w_cnt;
            OP_RR_ADDR:  r_col <= r_start + r_k;
            OP_RR: begin
                if (r_room_q != '0) begin
                    r_rem     <= r_rem - SW'(1);
                    r_changed <= 1'b1;
                    if (r_room_q == WIDTH_BITS'(1)) r_active <= r_active - CFG_W'(1);
                end
                r_k   <= w_knext;
                r_j   <= r_j + CFG_W'(1);
                r_col <= r_start + w_knext;
            end
            OP_PASS_INC:  r_pass <= r_pass + CFG_W'(1);
            OP_EMIT_INIT: r_col <= '0;
            OP_EMIT: begin
                r_od.out_column <= r_col[COL_W-1:0];
                r_od.out_width  <= FIELD_W'(r_width_q);
                r_od.changed    <= r_changed;
                r_od.last       <= (r_col + CFG_W'(1) == r_n);
                r_col           <= r_col + CFG_W'(1);
            end
            default: r_col <= r_col;
        endcase
    end

    pcwr_div #(
        .DW (SW),
        .VW (CFG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_START),
        .i_dividend (r_rem),
        .i_divisor  (r_active),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    always_comb begin
        o_status.cmd         = r_item.command;
        o_status.col_in_use  = w_focus < r_n;
        o_status.at_end      = r_col == r_n;
        o_status.scope_empty = r_start >= r_n;
        o_status.delta_zero  = r_sum == w_target;
        o_status.rem_zero    = r_rem == '0;
        o_status.found       = r_found;
        o_status.share_cont  = ({1'b0, r_pass} <= w_cnt1) && (r_rem != '0) &&
                               (r_active != '0);
        o_status.rr_needed   = (r_rem != '0) && (r_rem < SW'(r_active));
        o_status.mod_done    = r_k < w_cnt;
        o_status.rr_cont     = (r_j < w_cnt) && (r_rem != '0);
        o_status.div_done    = !w_div_busy;
        o_status.out_free    = w_out_free;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
endmodule
`default_nettype wire

@@ rtl/priority_column_width_resizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// priority_column_width_resizer
// column width table with priority-ordered water-fill resizing
// ----------------------------------------------------------------------------
// Commands are taken one at a time; i_valid/o_stall take one beat, results
// leave on o_valid/i_stall, one beat per column in use for a resize, one
// beat for a read, none for writes. Each visit to a column takes a read
// state and an operate state because every column table is a memory with a
// registered read port. A resize runs a sum walk over all n columns and a
// flexibility walk over the scope, then per priority level present in the
// scope a search walk and a room walk, and per water-fill round a divider
// pass over the SW-bit remainder (SW = WIDTH_BITS+7, at least 17) plus a
// share walk and, when a remainder below the active column count is left, a
// round-robin walk that hands out single pixels. Resize one runs up to three
// scopes. Writes finish in the execute state after the load. Configuration
// (num_columns at byte address 0) is written over the register port.
// ----------------------------------------------------------------------------
module priority_column_width_resizer
    import pcwr_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int unsigned WIDTH_BITS  = WIDTH_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // command channel
    input  wire logic               i_valid,
    input  wire t_in_item           i_data,
    output logic                    o_stall,
    // result channel
    output logic                    o_valid,
    output t_out_item               o_data,
    input  wire logic               i_stall,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [CFG_W-1:0] r_num_columns;
    logic             w_idle;
    logic             w_accept;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;

    // num_columns register, a write beyond it is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_columns <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_NUM_COLUMNS) begin
            r_num_columns <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_NUM_COLUMNS) ? 32'(r_num_columns) : '0;
    assign pready = 1'b1;

    // one command in flight, held off until the sequencer is back at rest
    assign o_stall  = !w_idle;
    assign w_accept = i_valid && w_idle;

    pcwr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_idle   (w_idle)
    );

    pcwr_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .WIDTH_BITS  (WIDTH_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_item        (i_data),
        .i_num_columns (r_num_columns),
        .i_out_stall   (i_stall),
        .o_status      (w_status),
        .o_out_valid   (o_valid),
        .o_out_data    (o_data)
    );
endmodule
`default_nettype wire

@@ tb/priority_column_width_resizer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_column_width_resizer_test
// self-checking bench: commands from a queue, results checked against a
// behavioral model of the priority water-fill resizer
// ----------------------------------------------------------------------------
module priority_column_width_resizer_test;
    import pcwr_pkg::*;

    localparam int NCOL = 16;
    localparam longint WMAX = 65535;
    localparam int LONG_HOLD = 3000;
    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;
    localparam logic [PADDR_W-1:0] ADDR_NUM_COLUMNS = 3'd0;

    logic i_clk, i_rst_n;
    logic i_valid, i_stall;
    t_in_item i_data;
    logic o_stall, o_valid;
    t_out_item o_data;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    priority_column_width_resizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_data(i_data), .o_stall(o_stall),
        .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow copy of the column tables
    int unsigned col_min [NCOL];
    int unsigned col_max [NCOL];
    bit          col_bnd [NCOL];
    byte unsigned col_pri [NCOL];
    int unsigned col_wid [NCOL];
    int unsigned rr_ptr;
    int unsigned num_cols_reg;

    // scratch for the water-fill
    longint fill_dest [NCOL];
    longint fill_lim  [NCOL];

    t_in_item  cmd_queue [$];
    t_out_item width_reports [$];

    int tx_idle_pct, rx_stall_pct;
    bit tx_hold;
    logic hold_go;
    int hold_cnt;
    int mismatches, beats_checked, cmds_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int scope_cols();
        return (num_cols_reg > NCOL) ? NCOL : int'(num_cols_reg);
    endfunction

    // even split of total over fill_lim, remainder from the round-robin pointer
    function automatic void water_fill(int cnt, longint total);
        longint rem, each, room, add;
        int active, i, j, k, pass;
        rem = total;
        active = 0;
        for (i = 0; i < cnt; i++) if (fill_lim[i] > 0) active++;
        for (pass = 0; pass <= cnt + 1 && rem > 0 && active > 0; pass++) begin
            each = rem / active;
            for (i = 0; i < cnt && rem > 0; i++) begin
                room = fill_lim[i] - fill_dest[i];
                if (room > 0) begin
                    add = (room < each) ? room : each;
                    fill_dest[i] += add;
                    rem -= add;
                    if (fill_dest[i] == fill_lim[i]) active--;
                end
            end
            if (rem > 0 && rem < active) begin
                for (j = 0; j < cnt && rem > 0; j++) begin
                    k = rr_ptr % cnt;
                    if (fill_dest[k] < fill_lim[k]) begin
                        fill_dest[k] += 1;
                        rem -= 1;
                        if (fill_dest[k] == fill_lim[k]) active--;
                    end
                    rr_ptr = ((k + 1) % cnt) & 6'h3f;
                end
            end
        end
    endfunction

    function automatic longint width_sum(int from, int to);
        longint s;
        s = 0;
        for (int k = from; k < to; k++) s += col_wid[k];
        return s;
    endfunction

    // fit columns start..n-1 to target, highest priority first
    function automatic bit fit_range(int start, int n, longint target);
        longint flex [NCOL];
        longint delta, need, rem, cur, f, w;
        int cnt, c;
        bit grow, chg, present, here;
        cnt = n - start;
        chg = 0;
        if (cnt <= 0) return 0;
        delta = target - width_sum(start, n);
        if (delta == 0) return 0;
        grow = delta > 0;
        need = grow ? delta : -delta;
        for (int k = 0; k < cnt; k++) begin
            c = start + k;
            cur = col_wid[c];
            if (grow) begin
                if (col_bnd[c]) f = (cur > col_max[c]) ? 0 : longint'(col_max[c]) - cur;
                else begin
                    f = need;
                    if (f > WMAX - cur) f = WMAX - cur;
                end
            end else begin
                f = (cur < col_min[c]) ? 0 : cur - longint'(col_min[c]);
            end
            flex[k] = (f < 0) ? 0 : f;
        end
        rem = need;
        for (int p = 255; p >= 0 && rem > 0; p--) begin
            present = 0;
            for (int k = 0; k < cnt; k++) begin
                here = col_pri[start + k] == p[7:0];
                fill_lim[k] = here ? flex[k] : 0;
                fill_dest[k] = 0;
                if (here) present = 1;
            end
            if (present) begin
                water_fill(cnt, rem);
                for (int k = 0; k < cnt; k++) begin
                    if (fill_dest[k] != 0) begin
                        w = col_wid[start + k];
                        w = grow ? w + fill_dest[k] : w - fill_dest[k];
                        col_wid[start + k] = int'(w & WMAX);
                        rem -= fill_dest[k];
                        chg = 1;
                    end
                end
            end
        end
        return chg;
    endfunction

    // apply one accepted command to the shadow tables and queue its reports
    function automatic void apply_command(t_in_item it);
        int n, col;
        longint target, w, orig;
        bit chg;
        t_out_item r;
        n = scope_cols();
        col = it.column;
        target = it.total_width;
        chg = 0;
        case (it.command)
            CMD_WRITE_SPEC: begin
                if (col < NCOL) begin
                    col_min[col] = it.min_width;
                    col_max[col] = (it.max_width < it.min_width) ? it.min_width : it.max_width;
                    col_bnd[col] = it.has_max;
                    col_pri[col] = it.priority_req;
                end
                return;
            end
            CMD_WRITE_WIDTH: begin
                if (col < NCOL) col_wid[col] = it.width_value;
                return;
            end
            CMD_READ_WIDTH: begin
                r.out_column = it.column;
                r.out_width = (col < NCOL) ? col_wid[col][15:0] : '0;
                r.changed = 1'b0;
                r.last = 1'b1;
                width_reports.push_back(r);
                return;
            end
            CMD_RESIZE_ALL: chg = fit_range(0, n, target);
            CMD_RESIZE_ONE: begin
                if (col < n) begin
                    w = col_wid[col];
                    orig = w;
                    if (w < col_min[col]) w = col_min[col];
                    if (col_bnd[col] && w > col_max[col]) w = col_max[col];
                    col_wid[col] = int'(w);
                    chg = w != orig;
                    if (fit_range(col + 1, n, target - width_sum(0, col + 1))) chg = 1;
                    if (target != width_sum(0, n)) begin
                        if (fit_range(col, n, target - width_sum(0, col))) chg = 1;
                        if (target != width_sum(0, n))
                            if (fit_range(0, n, target)) chg = 1;
                    end
                end
            end
            default: return;
        endcase
        for (int k = 0; k < n; k++) begin
            r.out_column = k[5:0];
            r.out_width = col_wid[k][15:0];
            r.changed = chg;
            r.last = (k == n - 1);
            width_reports.push_back(r);
        end
    endfunction

    // driver: offer queued commands, predict at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) begin
                    apply_command(i_data);
                    cmds_sent++;
                end
                if (cmd_queue.size() != 0 && !tx_hold &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    i_valid <= 1'b1;
                    i_data <= cmd_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_go) hold_cnt <= LONG_HOLD;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    // monitor: random stall, compare each beat with the oldest expected report
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (width_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: col %0d width %0d", o_data.out_column,
                                 o_data.out_width);
                end else begin
                    e = width_reports.pop_front();
                    beats_checked++;
                    if (o_data.out_column !== e.out_column || o_data.out_width !== e.out_width ||
                        o_data.changed !== e.changed || o_data.last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: exp col %0d w %0d chg %0d last %0d, ",
                                   e.out_column, e.out_width, e.changed, e.last);
                            $display("got col %0d w %0d chg %0d last %0d",
                                     o_data.out_column, o_data.out_width, o_data.changed,
                                     o_data.last);
                        end
                    end
                end
            end
            i_stall <= (hold_cnt != 0) || ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [5:0] col, logic [15:0] mn,
                             logic [15:0] mx, logic hm, logic [7:0] pr, logic [15:0] wv,
                             logic [15:0] tw);
        t_in_item it;
        it.command = cmd; it.column = col; it.min_width = mn; it.max_width = mx;
        it.has_max = hm; it.priority_req = pr; it.width_value = wv; it.total_width = tw;
        cmd_queue.push_back(it);
    endtask

    // everything sent and answered, plus a margin for a trailing write
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || i_valid || width_reports.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_num_columns(int unsigned v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_NUM_COLUMNS; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        num_cols_reg = v & 7'h7f;
    endtask

    // random command mix of all five commands and the spare codes
    task automatic random_cmds(int count);
        int sel;
        logic [5:0] col;
        logic [15:0] a, b;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            col = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(15));
            a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
            b = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(800));
            if (sel < 20)
                queue_cmd(CMD_WRITE_SPEC, col, a, b, 1'($urandom),
                          ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                          16'($urandom), 16'($urandom));
            else if (sel < 35)
                queue_cmd(CMD_WRITE_WIDTH, col, 16'($urandom), 16'($urandom), 1'($urandom),
                          8'($urandom), b, 16'($urandom));
            else if (sel < 55)
                queue_cmd(CMD_RESIZE_ALL, col, 16'($urandom), 16'($urandom), 1'($urandom),
                          8'($urandom),16'($urandom),
                          ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(6000)));
            else if (sel < 80)
                queue_cmd(CMD_RESIZE_ONE, col, 16'($urandom), 16'($urandom), 1'($urandom),
                          8'($urandom), 16'($urandom),
                          ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(6000)));
            else if (sel < 95)
                queue_cmd(CMD_READ_WIDTH, col, 16'($urandom), 16'($urandom), 1'($urandom),
                          8'($urandom), 16'($urandom), 16'($urandom));
            else
                queue_cmd(CMD_SPARE_A + 3'($urandom_range(2)), col, 16'($urandom), 16'($urandom),
                          1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        hold_go = 1'b0; hold_cnt = 0; tx_hold = 0;
        tx_idle_pct = 0; rx_stall_pct = 0;
        mismatches = 0; beats_checked = 0; cmds_sent = 0;
        rr_ptr = 0; num_cols_reg = 0;
        for (int k = 0; k < NCOL; k++) begin
            col_min[k] = 0; col_max[k] = 0; col_bnd[k] = 0; col_pri[k] = 0; col_wid[k] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_num_columns(16);
        // fill every table entry before anything reads one
        for (int k = 0; k < NCOL; k++) begin
            queue_cmd(CMD_WRITE_SPEC, k[5:0], 16'(10 * k), 16'(100 + 20 * k), k[0],
                      8'(k % 3), 16'h0, 16'h0);
            queue_cmd(CMD_WRITE_WIDTH, k[5:0], 16'h0, 16'h0, 1'b0, 8'h0, 16'(50 + k), 16'h0);
        end
        // directed corners
        queue_cmd(CMD_WRITE_SPEC, 6'd3, 16'd500, 16'd20, 1'b1, 8'hff, 16'h0, 16'h0);
        queue_cmd(CMD_WRITE_SPEC, 6'd4, 16'hffff, 16'hffff, 1'b0, 8'h00, 16'h0, 16'h0);
        queue_cmd(CMD_WRITE_SPEC, 6'd40, 16'd1, 16'd2, 1'b1, 8'd7, 16'h0, 16'h0);
        queue_cmd(CMD_WRITE_WIDTH, 6'd63, 16'h0, 16'h0, 1'b0, 8'h0, 16'hffff, 16'h0);
        queue_cmd(CMD_WRITE_WIDTH, 6'd5, 16'h0, 16'h0, 1'b0, 8'h0, 16'hffff, 16'h0);
        queue_cmd(CMD_READ_WIDTH, 6'd0, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'h0);
        queue_cmd(CMD_READ_WIDTH, 6'd63, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'h0);
        queue_cmd(CMD_RESIZE_ALL, 6'd0, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'h0);
        queue_cmd(CMD_RESIZE_ALL, 6'd0, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'hffff);
        queue_cmd(CMD_RESIZE_ALL, 6'd0, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'd3001);
        queue_cmd(CMD_RESIZE_ALL, 6'd0, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'd3001);
        queue_cmd(CMD_RESIZE_ONE, 6'd0, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'd2000);
        queue_cmd(CMD_RESIZE_ONE, 6'd15, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'd2500);
        queue_cmd(CMD_RESIZE_ONE, 6'd3, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'd1999);
        queue_cmd(CMD_RESIZE_ONE, 6'd63, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'd100);
        queue_cmd(CMD_SPARE_A, 6'd1, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'h0);
        queue_cmd(CMD_SPARE_B, 6'd1, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'h0);
        queue_cmd(CMD_SPARE_C, 6'd1, 16'h0, 16'h0, 1'b0, 8'h0, 16'h0, 16'h0);
        wait_drained();

        // no idling, then a sender pause mid-phase
        random_cmds(10);
        tx_hold = 1;
        while (i_valid || width_reports.size() != 0) @(posedge i_clk);
        tx_hold = 0;
        random_cmds(5);
        wait_drained();

        // sender mostly idle, one column
        set_num_columns(1);
        tx_idle_pct = 76;
        random_cmds(15);
        wait_drained();

        // receiver mostly stalling, no columns in use, then a few
        set_num_columns(0);
        tx_idle_pct = 0; rx_stall_pct = 76;
        random_cmds(8);
        wait_drained();
        set_num_columns(7);
        random_cmds(15);
        wait_drained();

        // oversized count, long receiver hold-off while commands pile up
        set_num_columns(64);
        rx_stall_pct = 0;
        @(posedge i_clk) hold_go <= 1'b1;
        @(posedge i_clk) hold_go <= 1'b0;
        random_cmds(20);
        wait_drained();

        // both sides idling
        set_num_columns(16);
        tx_idle_pct = 34; rx_stall_pct = 34;
        random_cmds(20);
        wait_drained();
        tx_idle_pct = 0; rx_stall_pct = 0;
        repeat (200) @(posedge i_clk);

        $display("covered %0d commands and %0d width beats over six column counts",
                 cmds_sent, beats_checked);
        if (mismatches == 0 && width_reports.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
